FILE: rtl/cds_pkg.sv
`default_nettype none
package cds_pkg;

  localparam int unsigned PositionBitsDef = 32;
  localparam int unsigned StepBits        = 20;
  localparam int unsigned PortPosBits     = 32;
  localparam logic [StepBits-1:0] HomeStepRst = 20'd1000;

  // config register indexes
  localparam logic REG_HOME_STEP = 1'b0;

  // command codes
  localparam logic [2:0] REQ_NONE   = 3'd0;
  localparam logic [2:0] REQ_ENABLE = 3'd1;
  localparam logic [2:0] REQ_RESET  = 3'd2;
  localparam logic [2:0] REQ_QSTOP  = 3'd3;
  localparam logic [2:0] REQ_HOME   = 3'd4;

  // control words
  localparam logic [15:0] CW_DISABLE  = 16'h0000;
  localparam logic [15:0] CW_QSTOP    = 16'h0002;
  localparam logic [15:0] CW_SHUTDOWN = 16'h0006;
  localparam logic [15:0] CW_SWITCHON = 16'h0007;
  localparam logic [15:0] CW_ENABLE   = 16'h000F;
  localparam logic [15:0] CW_FLTRST   = 16'h0080;

  // status word masks and patterns
  localparam logic [15:0] SW_MASK_A    = 16'h004F;
  localparam logic [15:0] SW_MASK_B    = 16'h006F;
  localparam logic [15:0] SW_NOTREADY  = 16'h0000;
  localparam logic [15:0] SW_SWONDIS   = 16'h0040;
  localparam logic [15:0] SW_READY     = 16'h0021;
  localparam logic [15:0] SW_SWON      = 16'h0023;
  localparam logic [15:0] SW_OPEN      = 16'h0027;
  localparam logic [15:0] SW_QSTOP     = 16'h0007;
  localparam logic [15:0] SW_FLTREACT  = 16'h000F;
  localparam logic [15:0] SW_FAULT     = 16'h0008;

  typedef enum logic [2:0] {
    ST_NOT_READY  = 3'd0,
    ST_SW_ON_DIS  = 3'd1,
    ST_READY      = 3'd2,
    ST_SWITCHED   = 3'd3,
    ST_OP_ENABLED = 3'd4,
    ST_QUICK_STOP = 3'd5,
    ST_FLT_REACT  = 3'd6,
    ST_FAULT      = 3'd7
  } drive_state_t;

  typedef struct packed {
    logic home;
    logic stop;
    logic power;
    logic reset;
  } busy_t;

  typedef struct packed {
    drive_state_t state;
    logic [15:0]  ctrl;
    busy_t        busy;
    logic         armed;
    logic         motion;
  } cds_flags_t;

  // first match wins; no match keeps the previous state
  function automatic drive_state_t decode_state(input logic [15:0] sw,
                                                input drive_state_t prev);
    drive_state_t st;
    st = prev;
    priority if ((sw & SW_MASK_A) == SW_NOTREADY) st = ST_NOT_READY;
    else if ((sw & SW_MASK_A) == SW_SWONDIS)      st = ST_SW_ON_DIS;
    else if ((sw & SW_MASK_B) == SW_READY)        st = ST_READY;
    else if ((sw & SW_MASK_B) == SW_SWON)         st = ST_SWITCHED;
    else if ((sw & SW_MASK_B) == SW_OPEN)         st = ST_OP_ENABLED;
    else if ((sw & SW_MASK_B) == SW_QSTOP)        st = ST_QUICK_STOP;
    else if ((sw & SW_MASK_A) == SW_FLTREACT)     st = ST_FLT_REACT;
    else if ((sw & SW_MASK_A) == SW_FAULT)        st = ST_FAULT;
    else                                          st = prev;
    return st;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cds_apb_regs.sv
`default_nettype none
module cds_apb_regs
  import cds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output logic      [StepBits-1:0] step_len
);

  logic [StepBits-1:0] home_step_r;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HOME_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_step_r <= HomeStepRst;
    end else if (wr_en) begin
      home_step_r <= pwdata[StepBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HOME_STEP) begin
      prdata = {{(32-StepBits){1'b0}}, home_step_r};
    end
  end

  assign step_len = home_step_r;

endmodule
`default_nettype wire

FILE: rtl/cds_step.sv
`default_nettype none
module cds_step
  import cds_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBitsDef
)
(
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire logic [StepBits-1:0]             step_len,
  input  wire logic [15:0]                     status_in,
  input  wire logic signed [POSITION_BITS-1:0] actual,
  input  wire logic [2:0]                      req_type,
  input  wire logic                            arm_origin,
  output cds_flags_t                           flags,
  output logic signed [POSITION_BITS-1:0]      target,
  output logic signed [POSITION_BITS-1:0]      origin,
  output logic                                 changed
);

  localparam int unsigned CW = ((POSITION_BITS > StepBits) ? POSITION_BITS : StepBits) + 2;

  cds_flags_t                      flags_r, flags_nxt;
  logic signed [POSITION_BITS-1:0] target_r, target_nxt;
  logic signed [POSITION_BITS-1:0] origin_r, origin_nxt;
  logic                            changed_r, changed_nxt;
  drive_state_t                    cur;
  logic signed [CW-1:0]            t_ext, s_ext, diff, sum;
  logic                            act_pos, act_neg;

  assign t_ext   = CW'(target_r);
  assign s_ext   = signed'(CW'(step_len));
  assign diff    = t_ext - s_ext;
  assign sum     = t_ext + s_ext;
  assign act_neg = actual[POSITION_BITS-1];
  assign act_pos = !act_neg && (actual != '0);

  always_comb begin
    cur         = decode_state(status_in, flags_r.state);
    changed_nxt = (cur != flags_r.state);
    flags_nxt   = flags_r;
    flags_nxt.state = cur;
    flags_nxt.armed = flags_r.armed | arm_origin;
    target_nxt  = target_r;
    origin_nxt  = origin_r;

    unique case (req_type)
      REQ_ENABLE: begin
        flags_nxt.busy.power = 1'b1;
        unique case (cur)
          ST_NOT_READY: ;
          ST_SW_ON_DIS: flags_nxt.ctrl = CW_SHUTDOWN;
          ST_READY:     flags_nxt.ctrl = CW_SWITCHON;
          ST_SWITCHED: begin
            flags_nxt.ctrl = CW_ENABLE;
            target_nxt     = actual;
            if (flags_nxt.armed) begin
              origin_nxt      = actual;
              flags_nxt.armed = 1'b0;
            end
          end
          ST_OP_ENABLED: begin
            flags_nxt.busy.reset = 1'b0;
            flags_nxt.busy.power = 1'b0;
            flags_nxt.busy.stop  = 1'b0;
            flags_nxt.motion     = 1'b1;
          end
          default: flags_nxt.busy.reset = 1'b1;
        endcase
      end
      REQ_RESET: begin
        flags_nxt.busy.reset = 1'b1;
        unique case (cur)
          ST_READY, ST_SWITCHED, ST_OP_ENABLED: flags_nxt.ctrl = CW_DISABLE;
          ST_FLT_REACT, ST_FAULT:               flags_nxt.ctrl = CW_FLTRST;
          ST_SW_ON_DIS: begin
            flags_nxt.busy.reset = 1'b0;
            flags_nxt.busy.stop  = 1'b0;
            flags_nxt.busy.power = 1'b1;
            flags_nxt.motion     = 1'b0;
          end
          default: ;
        endcase
      end
      REQ_QSTOP: begin
        flags_nxt.busy.stop = 1'b1;
        if (cur == ST_OP_ENABLED) begin
          flags_nxt.ctrl = CW_QSTOP;
        end else if (cur == ST_QUICK_STOP || cur == ST_SW_ON_DIS) begin
          flags_nxt.busy   = '0;
          flags_nxt.motion = 1'b0;
        end
      end
      REQ_HOME: begin
        flags_nxt.busy.home = 1'b1;
        // ramp toward zero, clamp and finish when the step would cross it
        if (act_pos) begin
          if (diff < 0) begin
            target_nxt     = '0;
            flags_nxt.busy = '0;
          end else begin
            target_nxt = diff[POSITION_BITS-1:0];
          end
        end else if (act_neg) begin
          if (sum > 0) begin
            target_nxt     = '0;
            flags_nxt.busy = '0;
          end else begin
            target_nxt = sum[POSITION_BITS-1:0];
          end
        end else begin
          target_nxt     = '0;
          flags_nxt.busy = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '{state: ST_NOT_READY, ctrl: '0, busy: '0, armed: 1'b0, motion: 1'b0};
      target_r  <= '0;
      origin_r  <= '0;
      changed_r <= 1'b0;
    end else if (adv) begin
      flags_r   <= flags_nxt;
      target_r  <= target_nxt;
      origin_r  <= origin_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign flags   = flags_r;
  assign target  = target_r;
  assign origin  = origin_r;
  assign changed = changed_r;

  // held state must not move without an item advancing
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(flags_r) && $stable(target_r) && $stable(origin_r)))
    else $error("state moved without an item");

  // changed flag reflects the state transition of the last item
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (changed_r == (flags_r.state != $past(flags_r.state))))
    else $error("state_changed inconsistent");

  // a finished homing leaves the target at zero with no busy flags
  a_home_done: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && req_type == REQ_HOME && actual == '0) |=> (target_r == '0 && flags_r.busy == '0))
    else $error("homing at origin did not finish");

endmodule
`default_nettype wire

FILE: rtl/cia402_drive_sequencer_unit.sv
// Drive sequencer for a CiA 402 style servo drive.
// Input channel (in_valid/in_ready): one request per communication cycle carrying
// the status word, the actual position, a command code and the origin-arm bit.
// Result channel (out_valid/out_ready): one result per request with the held
// control word, target position, decoded drive state, state-change flag, the
// four busy flags, motion-allowed and the captured origin.
// Config port (cfg_*): APB-style, homing step register at byte address 0;
// write only while no request is in flight.
// Throughput: one request per clock while the receiver keeps up. A request
// passes the input register, then the state/result register, to out_valid.
// The state registers double as the result register, so each request sees
// the state left by the one before it.
// Reset (synchronous, rst_n low): drive state not-ready, control word,
// target and origin zero, all flags clear, homing step 1000, both valids low.
// When the receiver stalls, the result holds; one more request is buffered
// in the input register, after which in_ready drops.
`default_nettype none
module cia402_drive_sequencer_unit
  import cds_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBitsDef
)
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [15:0]             in_status_word,
  input  wire logic signed [31:0]      in_actual_position,
  input  wire logic [2:0]              in_req_type,
  input  wire logic                    in_arm_origin,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [15:0]                  out_control_word,
  output logic signed [31:0]           out_target_position,
  output logic [2:0]                   out_drive_state,
  output logic                         out_state_changed,
  output logic                         out_reset_pending,
  output logic                         out_power_pending,
  output logic                         out_stop_pending,
  output logic                         out_homing_pending,
  output logic                         out_motion_allowed,
  output logic signed [31:0]           out_origin_position,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [2:0]              cfg_paddr,
  input  wire logic [31:0]             cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int unsigned ExtBits =
    (POSITION_BITS > PortPosBits) ? POSITION_BITS : PortPosBits;

  // input register
  logic                            in_vld_r;
  logic [15:0]                     sw_r;
  logic signed [POSITION_BITS-1:0] act_r;
  logic [2:0]                      req_r;
  logic                            arm_r;
  logic                            out_vld_r;
  logic                            adv;

  logic [StepBits-1:0]             step_len;
  cds_flags_t                      flags;
  logic signed [POSITION_BITS-1:0] target, origin;
  logic signed [ExtBits-1:0]       target_ext, origin_ext;
  logic                            changed;

  // an item moves into the result register when that slot is free or drains
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sw_r  <= in_status_word;
      act_r <= POSITION_BITS'(in_actual_position);
      req_r <= in_req_type;
      arm_r <= in_arm_origin;
    end
  end

  cds_apb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .step_len  (step_len)
  );

  cds_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .step_len    (step_len),
    .status_in   (sw_r),
    .actual      (act_r),
    .req_type    (req_r),
    .arm_origin  (arm_r),
    .flags       (flags),
    .target      (target),
    .origin      (origin),
    .changed     (changed)
  );

  // positions are reported as the low 32 bits of the sign-extended value
  assign target_ext = ExtBits'(target);
  assign origin_ext = ExtBits'(origin);

  assign out_valid           = out_vld_r;
  assign out_control_word    = flags.ctrl;
  assign out_target_position = target_ext[PortPosBits-1:0];
  assign out_drive_state     = flags.state;
  assign out_state_changed   = changed;
  assign out_reset_pending   = flags.busy.reset;
  assign out_power_pending   = flags.busy.power;
  assign out_stop_pending    = flags.busy.stop;
  assign out_homing_pending  = flags.busy.home;
  assign out_motion_allowed  = flags.motion;
  assign out_origin_position = origin_ext[PortPosBits-1:0];

  // empty result slot never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with empty result slot");

  // a drained result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && !in_vld_r) |=> !out_vld_r)
    else $error("result repeated");

  // every advanced item shows up as a valid result
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced item lost");

endmodule
`default_nettype wire

FILE: tb/sv/cds_tb_pkg.sv
package cds_tb_pkg;
  import cds_pkg::*;

  typedef struct {
    logic [15:0] control_word;
    logic [31:0] target_pos;
    logic [2:0]  state_code;
    logic        state_changed;
    logic        reset_pending;
    logic        power_pending;
    logic        stop_pending;
    logic        homing_pending;
    logic        motion_allowed;
    logic [31:0] origin_position;
  } drive_response_t;

  // Shadow copy of the sequencer state and the queue of responses it owes.
  class drive_response_board;
    logic [19:0]     step_len;
    drive_state_t    cur_state;
    drive_state_t    last_state;
    logic [15:0]     ctrl;
    longint          target;
    longint          origin;
    bit              armed;
    busy_t           busy;
    bit              motion;
    drive_response_t awaited[$];
    int unsigned     checked;
    int unsigned     mismatches;

    function new();
      step_len   = HomeStepRst;
      cur_state  = ST_NOT_READY;
      last_state = ST_NOT_READY;
      ctrl       = CW_DISABLE;
      target     = 0;
      origin     = 0;
      armed      = 1'b0;
      busy       = '0;
      motion     = 1'b0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void set_home_step(logic [19:0] value);
      step_len = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // mask priority decode, no match keeps the old state
    function drive_state_t decode_status(logic [15:0] sw, drive_state_t prev);
      logic [15:0] a;
      logic [15:0] b;
      a = sw & SW_MASK_A;
      b = sw & SW_MASK_B;
      if (a == SW_NOTREADY) return ST_NOT_READY;
      if (a == SW_SWONDIS) return ST_SW_ON_DIS;
      if (b == SW_READY) return ST_READY;
      if (b == SW_SWON) return ST_SWITCHED;
      if (b == SW_OPEN) return ST_OP_ENABLED;
      if (b == SW_QSTOP) return ST_QUICK_STOP;
      if (a == SW_FLTREACT) return ST_FLT_REACT;
      if (a == SW_FAULT) return ST_FAULT;
      return prev;
    endfunction

    function void note_request(logic [15:0] sw, logic signed [31:0] pos,
                               logic [2:0] req, logic arm);
      longint          pos_l;
      longint          step_l;
      bit              done;
      drive_response_t r;
      pos_l  = pos;
      step_l = step_len;
      done   = 1'b0;

      cur_state       = decode_status(sw, cur_state);
      r.state_changed = (cur_state != last_state);
      last_state      = cur_state;
      if (arm) armed = 1'b1;

      case (req)
        REQ_ENABLE: begin
          busy.power = 1'b1;
          case (cur_state)
            ST_NOT_READY: ;
            ST_SW_ON_DIS: ctrl = CW_SHUTDOWN;
            ST_READY: ctrl = CW_SWITCHON;
            ST_SWITCHED: begin
              ctrl   = CW_ENABLE;
              target = pos_l;
              if (armed) begin
                origin = pos_l;
                armed  = 1'b0;
              end
            end
            ST_OP_ENABLED: begin
              busy.reset = 1'b0;
              busy.power = 1'b0;
              busy.stop  = 1'b0;
              motion     = 1'b1;
            end
            default: busy.reset = 1'b1;
          endcase
        end
        REQ_RESET: begin
          busy.reset = 1'b1;
          case (cur_state)
            ST_READY, ST_SWITCHED, ST_OP_ENABLED: ctrl = CW_DISABLE;
            ST_FLT_REACT, ST_FAULT: ctrl = CW_FLTRST;
            ST_SW_ON_DIS: begin
              busy.reset = 1'b0;
              busy.stop  = 1'b0;
              busy.power = 1'b1;
              motion     = 1'b0;
            end
            default: ;
          endcase
        end
        REQ_QSTOP: begin
          busy.stop = 1'b1;
          if (cur_state == ST_OP_ENABLED) begin
            ctrl = CW_QSTOP;
          end else if (cur_state == ST_QUICK_STOP || cur_state == ST_SW_ON_DIS) begin
            busy   = '0;
            motion = 1'b0;
          end
        end
        REQ_HOME: begin
          busy.home = 1'b1;
          if (pos_l > 0) begin
            if (target < step_l) begin
              target = 0;
              done   = 1'b1;
            end else begin
              target -= step_l;
            end
          end else if (pos_l < 0) begin
            if (target > -step_l) begin
              target = 0;
              done   = 1'b1;
            end else begin
              target += step_l;
            end
          end else begin
            target = 0;
            done   = 1'b1;
          end
          if (done) busy = '0;
        end
        default: ;
      endcase

      r.control_word    = ctrl;
      r.target_pos      = target[31:0];
      r.state_code      = cur_state;
      r.reset_pending   = busy.reset;
      r.power_pending   = busy.power;
      r.stop_pending    = busy.stop;
      r.homing_pending  = busy.home;
      r.motion_allowed  = motion;
      r.origin_position = origin[31:0];
      awaited = {awaited, r};
    endfunction

    function void check_response(drive_response_t got);
      drive_response_t e;
      bit              bad;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] response %0d arrived with nothing outstanding", $time, checked);
        return;
      end
      e   = awaited.pop_front();
      bad = (e.control_word !== got.control_word) ||
            (e.target_pos !== got.target_pos) ||
            (e.state_code !== got.state_code) ||
            (e.state_changed !== got.state_changed) ||
            (e.reset_pending !== got.reset_pending) ||
            (e.power_pending !== got.power_pending) ||
            (e.stop_pending !== got.stop_pending) ||
            (e.homing_pending !== got.homing_pending) ||
            (e.motion_allowed !== got.motion_allowed) ||
            (e.origin_position !== got.origin_position);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] response %0d mismatch", $time, checked);
          $display("  exp cw %h tgt %h st %0d chg %b busy r%b p%b s%b h%b mot %b org %h",
                   e.control_word, e.target_pos, e.state_code, e.state_changed,
                   e.reset_pending, e.power_pending, e.stop_pending, e.homing_pending,
                   e.motion_allowed, e.origin_position);
          $display("  got cw %h tgt %h st %0d chg %b busy r%b p%b s%b h%b mot %b org %h",
                   got.control_word, got.target_pos, got.state_code,
                   got.state_changed, got.reset_pending, got.power_pending,
                   got.stop_pending, got.homing_pending, got.motion_allowed,
                   got.origin_position);
        end
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_cia402_drive_sequencer_unit.sv
module tb_cia402_drive_sequencer_unit;
  import cds_pkg::*;
  import cds_tb_pkg::*;

  localparam int unsigned IdlePct       = 14;    // chance of a gap / stall per cycle
  localparam int unsigned StallLimit    = 2000;  // cycles with no handshake at all
  localparam int unsigned PhaseRequests = 225;   // random requests per homing step setting
  localparam int unsigned HoldOffCycles = 80;    // long receiver hold-off

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        in_status_word;
  logic signed [31:0] in_actual_position;
  logic [2:0]         in_req_type;
  logic               in_arm_origin;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        out_control_word;
  logic signed [31:0] out_target_position;
  logic [2:0]         out_drive_state;
  logic               out_state_changed;
  logic               out_reset_pending;
  logic               out_power_pending;
  logic               out_stop_pending;
  logic               out_homing_pending;
  logic               out_motion_allowed;
  logic signed [31:0] out_origin_position;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  drive_response_board board;
  int unsigned         requests_sent;   // accepted requests so far
  int unsigned         stalled_cycles;  // watchdog count
  logic [19:0]         home_step_now;   // mirrors the value last written

  cia402_drive_sequencer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_status_word      (in_status_word),
    .in_actual_position  (in_actual_position),
    .in_req_type         (in_req_type),
    .in_arm_origin       (in_arm_origin),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_control_word    (out_control_word),
    .out_target_position (out_target_position),
    .out_drive_state     (out_drive_state),
    .out_state_changed   (out_state_changed),
    .out_reset_pending   (out_reset_pending),
    .out_power_pending   (out_power_pending),
    .out_stop_pending    (out_stop_pending),
    .out_homing_pending  (out_homing_pending),
    .out_motion_allowed  (out_motion_allowed),
    .out_origin_position (out_origin_position),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Status word that decodes to the given state; bits outside the mask are random.
  function automatic logic [15:0] status_for(input drive_state_t st);
    logic [15:0] r;
    r = 16'($urandom);
    case (st)
      ST_NOT_READY:  return (r & ~SW_MASK_A) | SW_NOTREADY;
      ST_SW_ON_DIS:  return (r & ~SW_MASK_A) | SW_SWONDIS;
      ST_READY:      return (r & ~SW_MASK_B) | SW_READY;
      ST_SWITCHED:   return (r & ~SW_MASK_B) | SW_SWON;
      ST_OP_ENABLED: return (r & ~SW_MASK_B) | SW_OPEN;
      ST_QUICK_STOP: return (r & ~SW_MASK_B) | SW_QSTOP;
      ST_FLT_REACT:  return (r & ~SW_MASK_A) | SW_FLTREACT;
      default:       return (r & ~SW_MASK_A) | SW_FAULT;
    endcase
  endfunction

  // Distance of a few homing steps, so ramps actually reach zero.
  function automatic logic signed [31:0] near_distance();
    int unsigned lim;
    lim = (home_step_now == 0) ? 1000 : 8 * home_step_now;
    return 32'($urandom_range(1, lim));
  endfunction

  function automatic logic signed [31:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0:       return 32'sd0;
        1:       return 32'sd1;
        2:       return -32'sd1;
        3:       return 32'sh7FFF_FFFF;
        default: return 32'sh8000_0000;
      endcase
    end
    if (r < 30) return 32'($urandom);
    return coin() ? -near_distance() : near_distance();
  endfunction

  // the sender stays busy without gaps over one window of requests
  function automatic bit sender_calm();
    return requests_sent >= 700 && requests_sent < 1000;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: valid goes up with the payload and stays until accepted.
  // ---------------------------------------------------------------------------

  task automatic offer_request(input logic [15:0] sw, input logic signed [31:0] pos,
                               input logic [2:0] req, input logic arm);
    int unsigned gap;
    gap = 0;
    while (!sender_calm() && $urandom_range(0, 99) < IdlePct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_status_word     <= sw;
    in_actual_position <= pos;
    in_req_type        <= req;
    in_arm_origin      <= arm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(sw, pos, req, arm);
    requests_sent++;
  endtask

  // Step of a well-formed sequence; now and then the status word or the
  // command gets corrupted so the sequence breaks.
  task automatic offer_step(input drive_state_t st, input logic signed [31:0] pos,
                            input logic [2:0] req, input logic arm);
    logic [15:0] sw;
    logic [2:0]  code;
    sw   = status_for(st);
    code = req;
    if ($urandom_range(0, 99) < 4) sw = 16'($urandom);
    if ($urandom_range(0, 99) < 4) code = 3'($urandom_range(0, 7));
    offer_request(sw, pos, code, arm);
  endtask

  // Power-up through the enable ladder, a homing ramp, then one of the ways out or none.
  task automatic run_power_up_and_home();
    logic signed [31:0] base;
    logic signed [31:0] pos;
    int unsigned        r;
    base = pick_position();
    offer_step(ST_SW_ON_DIS, pick_position(), REQ_ENABLE, coin());
    offer_step(ST_READY, pick_position(), REQ_ENABLE, coin());
    offer_step(ST_SWITCHED, base, REQ_ENABLE, coin());
    offer_step(ST_OP_ENABLED, pick_position(), REQ_ENABLE, 1'b0);
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 8) pos = 32'sd0;
      else if (r < 22) pos = pick_position();
      else pos = (base < 0) ? -near_distance() : near_distance();
      offer_step(ST_OP_ENABLED, pos, REQ_HOME, coin());
    end
    case ($urandom_range(0, 3))
      0: begin
        offer_step(ST_OP_ENABLED, pick_position(), REQ_QSTOP, 1'b0);
        offer_step(ST_QUICK_STOP, pick_position(), REQ_QSTOP, 1'b0);
        offer_step(ST_QUICK_STOP, pick_position(), REQ_ENABLE, coin());
      end
      1: begin
        offer_step(ST_FLT_REACT, pick_position(), REQ_ENABLE, 1'b0);
        offer_step(ST_FLT_REACT, pick_position(), REQ_RESET, 1'b0);
        offer_step(ST_FAULT, pick_position(), REQ_RESET, coin());
        offer_step(ST_SW_ON_DIS, pick_position(), REQ_RESET, 1'b0);
      end
      2: begin
        offer_step(ST_OP_ENABLED, pick_position(), REQ_RESET, 1'b0);
        offer_step(ST_SWITCHED, pick_position(), REQ_RESET, 1'b0);
        offer_step(ST_READY, pick_position(), REQ_NONE, 1'b0);
      end
      default: ;
    endcase
  endtask

  // Free noise: any status word, any command code including the unused ones.
  task automatic run_random_request();
    logic [15:0] sw;
    sw = coin() ? status_for(drive_state_t'($urandom_range(0, 7))) : 16'($urandom);
    offer_request(sw, pick_position(), 3'($urandom_range(0, 7)), coin());
  endtask

  // Drop valid and let every outstanding response come back, plus the
  // two-stage pipeline depth, before touching the register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_home_step(input logic [19:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * REG_HOME_STEP);
    cfg_pwdata  <= {12'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.set_home_step(value);
    home_step_now = value;
  endtask

  // Hand-picked opening: each state, each command, field extremes.
  task automatic run_directed();
    offer_request(SW_NOTREADY, 32'sd0, REQ_NONE, 1'b0);
    offer_request(SW_SWONDIS, 32'sd5, REQ_ENABLE, 1'b0);
    offer_request(SW_READY, -32'sd5, REQ_ENABLE, 1'b0);
    // arm and enable in one request: capture happens right away
    offer_request(SW_SWON, 32'sh7FFF_FFFF, REQ_ENABLE, 1'b1);
    offer_request(SW_OPEN, 32'sd0, REQ_ENABLE, 1'b0);
    offer_request(SW_OPEN, 32'sd77, REQ_HOME, 1'b0);
    offer_request(SW_OPEN, 32'sd0, REQ_HOME, 1'b0);       // zero actual ends homing
    offer_request(SW_SWON, 32'sh8000_0000, REQ_ENABLE, 1'b0);
    offer_request(SW_OPEN, -32'sd1, REQ_HOME, 1'b0);      // ramp up from the bottom
    offer_request(SW_OPEN, 32'sd1, REQ_HOME, 1'b0);       // wrong side clamps to zero
    offer_request(SW_OPEN, 32'sd3, REQ_QSTOP, 1'b0);
    offer_request(SW_QSTOP, 32'sd3, REQ_QSTOP, 1'b0);
    offer_request(SW_QSTOP, 32'sd3, REQ_ENABLE, 1'b0);    // enable from quick stop
    offer_request(SW_FLTREACT, 32'sd0, REQ_ENABLE, 1'b0); // enable from fault reaction
    offer_request(SW_FLTREACT, 32'sd0, REQ_RESET, 1'b0);
    offer_request(SW_FAULT, 32'sd0, REQ_RESET, 1'b0);
    offer_request(SW_FAULT, 32'sd0, REQ_ENABLE, 1'b0);
    offer_request(16'h0001, 32'sd9, 3'd5, 1'b0);          // no decode match, unused code
    offer_request(16'hFFFF, -32'sd9, 3'd6, 1'b0);
    offer_request(SW_SWONDIS, 32'sd0, REQ_RESET, 1'b0);
    offer_request(SW_SWONDIS, 32'sd0, REQ_QSTOP, 1'b0);
    offer_request(SW_READY, 32'sd0, REQ_RESET, 1'b0);
    offer_request(SW_NOTREADY, 32'sd0, 3'd7, 1'b1);
    offer_request(SW_NOTREADY, 32'sd0, REQ_HOME, 1'b0);
    offer_request(SW_NOTREADY, 32'sd0, REQ_QSTOP, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed requests, then one random phase per
  // homing step setting. The register is only written with the pipeline empty.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [19:0] settings [6];
    int unsigned quota;
    board              = new();
    requests_sent      = 0;
    home_step_now      = HomeStepRst;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_status_word     = '0;
    in_actual_position = '0;
    in_req_type        = REQ_NONE;
    in_arm_origin      = 1'b0;
    out_ready          = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    // smallest, largest, a stalled ramp, then random values
    settings[0] = 20'd1;
    settings[1] = 20'hF_FFFF;
    settings[2] = 20'd0;
    settings[3] = 20'($urandom_range(1, 20'hF_FFFF));
    settings[4] = 20'($urandom_range(1, 5000));
    settings[5] = 20'($urandom_range(1, 64));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // first phase runs on the reset value of the homing step
    run_directed();
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_home_step(settings[ph-1]);
      end
      quota = requests_sent + PhaseRequests;
      while (requests_sent < quota) begin
        if ($urandom_range(0, 99) < 65) run_power_up_and_home();
        else run_random_request();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, a window with none, and one long hold-off while
  // the sender keeps pushing so the pipeline backs up into in_ready.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold;
    bit          held_once;
    hold      = 0;
    held_once = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held_once && board.checked >= 400) begin
        held_once = 1'b1;
        hold      = HoldOffCycles;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (board.checked >= 900 && board.checked < 1200) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Response monitor: values are sampled as they stood before the edge.
  always @(posedge clk) begin : response_monitor
    drive_response_t got;
    if (rst_n && out_valid && out_ready) begin
      got.control_word    = out_control_word;
      got.target_pos      = out_target_position;
      got.state_code      = out_drive_state;
      got.state_changed   = out_state_changed;
      got.reset_pending   = out_reset_pending;
      got.power_pending   = out_power_pending;
      got.stop_pending    = out_stop_pending;
      got.homing_pending  = out_homing_pending;
      got.motion_allowed  = out_motion_allowed;
      got.origin_position = out_origin_position;
      board.check_response(got);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      stalled_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

endmodule

FILE: cia402_drive_sequencer_unit.f
rtl/cds_pkg.sv
rtl/cds_apb_regs.sv
rtl/cds_step.sv
rtl/cia402_drive_sequencer_unit.sv
tb/sv/cds_tb_pkg.sv
tb/sv/tb_cia402_drive_sequencer_unit.sv
